// ===== rtl/zmf_pkg.sv =====
`timescale 1ns / 1ps

package zmf_pkg;

    // window and zone geometry
    localparam int WINDOW = 9;
    localparam int ZONES  = 64;
    localparam int RANK   = WINDOW / 2;
    localparam int DEPTH  = WINDOW * ZONES;

    // field widths
    localparam int ZONE_W = 6;
    localparam int DIST_W = 12;
    localparam int STAT_W = 8;
    localparam int LIM_W  = 9;
    localparam int VAL_W  = 8;

    // derived widths
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIT_W  = (VAL_W > 1) ? $clog2(VAL_W) : 1;

    localparam logic [LIM_W-1:0] CLAMP_RESET = LIM_W'(510);

    // input beat
    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [DIST_W-1:0] distance_in;
        logic [STAT_W-1:0] tgt_status;
        logic              frame_end;
    } t_zmf_in;

    // output beat
    typedef struct packed {
        logic [ZONE_W-1:0] zone_out;
        logic [VAL_W-1:0]  median_value;
        logic              median_valid;
    } t_zmf_out;

    // history write request
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ZONE_W-1:0] zone;
        logic [VAL_W-1:0]  data;
    } t_zmf_wr;

    // history read stream
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] data;
    } t_zmf_rd;

    // population count over the window
    function automatic logic [CNT_W-1:0] count_ones(input logic [WINDOW-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WINDOW; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== rtl/zone_temporal_median_filter_unit.sv =====
`timescale 1ns / 1ps
// an in-range beat is written to the history, its zone is swept into the select unit, and
//   the median, resolved bit-serially, goes to the output register once that is free; one
//   beat at a time is in work, paced by the one-word-per-cycle history sweep (WINDOW reads)
//   and the bit-serial median (one result bit per cycle); out-of-range zones skip history
// reset: synchronous active low; clears slot, frame count, control and output valid,
//   loads clamp_limit with 510; history contents stay undefined until written

module zone_temporal_median_filter_unit
    import zmf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_zmf_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_zmf_out         o_out_data,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORK = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state            r_state;
    logic [LIM_W-1:0]  r_clamp_limit;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_frames;
    logic [ZONE_W-1:0] r_zone;
    logic              r_mvalid;
    logic [VAL_W-1:0]  r_med;
    logic              r_out_valid;
    t_zmf_out          r_out_data;

    logic              accept;
    logic              in_range;
    logic              reject;
    logic [LIM_W-1:0]  clamped;
    t_zmf_wr           wr;
    t_zmf_rd           rd;
    logic              sel_done;
    logic [VAL_W-1:0]  sel_median;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = ({1'b0, i_in_data.zone} < (ZONE_W + 1)'(ZONES));

    // clamp on limit or missing target, then halve
    assign reject  = (i_in_data.distance_in > DIST_W'(r_clamp_limit))
                  || (i_in_data.tgt_status == '0);
    assign clamped = reject ? r_clamp_limit : i_in_data.distance_in[LIM_W-1:0];

    assign wr.en   = accept && in_range;
    assign wr.slot = r_slot;
    assign wr.zone = i_in_data.zone;
    assign wr.data = clamped[LIM_W-1:1];

    zmf_history u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_start (wr.en),
        .i_zone  (i_in_data.zone),
        .o_rd    (rd)
    );

    zmf_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (rd),
        .o_done   (sel_done),
        .o_median (sel_median)
    );

    // clamp limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_limit <= CLAMP_RESET;
        end else if (i_cfg_we) begin
            r_clamp_limit <= i_cfg_wdata;
        end
    end

    // ring slot and completed frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_frames <= '0;
        end else if (accept && i_in_data.frame_end) begin
            r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
            if (r_frames < CNT_W'(WINDOW)) begin
                r_frames <= r_frames + CNT_W'(1);
            end
        end
    end

    // per-beat result holding
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_zone   <= i_in_data.zone;
            r_mvalid <= in_range && (r_frames >= CNT_W'(WINDOW - 1));
            r_med    <= '0;
        end else if (r_state == S_WORK && sel_done) begin
            r_med <= sel_median;
        end
    end

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= in_range ? S_WORK : S_PUSH;
                    end
                end
                S_WORK: begin
                    if (sel_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUSH && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && (!r_out_valid || i_out_ready)) begin
            r_out_data.zone_out     <= r_zone;
            r_out_data.median_value <= r_med;
            r_out_data.median_valid <= r_mvalid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/zmf_history.sv =====
`timescale 1ns / 1ps

module zmf_history
    import zmf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_zmf_wr           i_wr,
    input  logic              i_start,
    input  logic [ZONE_W-1:0] i_zone,
    output t_zmf_rd           o_rd
);

    logic [VAL_W-1:0]  r_mem [DEPTH];
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] r_addr;
    logic [SLOT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_rd_valid;
    logic [VAL_W-1:0]  r_rd_data;

    // slot-major address of the entry being written
    assign wr_addr = ADDR_W'(i_wr.slot) * ADDR_W'(ZONES) + ADDR_W'(i_wr.zone);

    // history write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
    end

    // registered read of the sweep address
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // sweep over all slots of one zone, one word per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_rd_valid <= 1'b0;
            r_cnt      <= '0;
            r_addr     <= '0;
        end else begin
            r_rd_valid <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_addr <= ADDR_W'(i_zone);
            end else if (r_busy) begin
                r_addr <= r_addr + ADDR_W'(ZONES);
                r_cnt  <= r_cnt + SLOT_W'(1);
                if (r_cnt == SLOT_W'(WINDOW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.data  = r_rd_data;

endmodule

// ===== rtl/zmf_select.sv =====
`timescale 1ns / 1ps

module zmf_select
    import zmf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_zmf_rd          i_rd,
    output logic             o_done,
    output logic [VAL_W-1:0] o_median
);

    logic [VAL_W-1:0]  r_word [WINDOW];
    logic [WINDOW-1:0] r_live;
    logic [SLOT_W-1:0] r_rank;
    logic [SLOT_W-1:0] r_ld_cnt;
    logic [BIT_W-1:0]  r_bit;
    logic              r_busy;
    logic              r_done;
    logic [VAL_W-1:0]  r_med;

    logic [WINDOW-1:0] msb;
    logic [CNT_W-1:0]  zeros;
    logic              ans_bit;
    logic [WINDOW-1:0] n_live;
    logic [SLOT_W-1:0] n_rank;

    // current top bit of every word and the tied words that show a zero
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            msb[i] = r_word[i][VAL_W-1];
        end
        zeros   = count_ones(r_live & ~msb);
        ans_bit = !(CNT_W'(r_rank) < zeros);
        if (ans_bit) begin
            n_live = r_live & msb;
            n_rank = SLOT_W'(CNT_W'(r_rank) - zeros);
        end else begin
            n_live = r_live & ~msb;
            n_rank = r_rank;
        end
    end

    // word shift line: load from the history stream, then shift one bit a step
    always_ff @(posedge i_clk) begin
        if (i_rd.valid) begin
            r_word[0] <= i_rd.data;
            for (int i = 1; i < WINDOW; i++) begin
                r_word[i] <= r_word[i-1];
            end
        end else if (r_busy) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_word[i] <= {r_word[i][VAL_W-2:0], 1'b0};
            end
        end
    end

    // msb-first rank selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_cnt <= '0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_bit    <= '0;
            r_live   <= '0;
            r_rank   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_rd.valid) begin
                if (r_ld_cnt == SLOT_W'(WINDOW - 1)) begin
                    r_ld_cnt <= '0;
                    r_busy   <= 1'b1;
                    r_bit    <= '0;
                    r_live   <= '1;
                    r_rank   <= SLOT_W'(RANK);
                end else begin
                    r_ld_cnt <= r_ld_cnt + SLOT_W'(1);
                end
            end else if (r_busy) begin
                r_live <= n_live;
                r_rank <= n_rank;
                r_bit  <= r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // answer bits arrive msb first and shift in at the lsb
    always_ff @(posedge i_clk) begin
        if (r_busy && !i_rd.valid) begin
            r_med <= {r_med[VAL_W-2:0], ans_bit};
        end
    end

    assign o_done   = r_done;
    assign o_median = r_med;

endmodule

// ===== rtl/zmf_checker.sv =====
`timescale 1ns / 1ps

module zmf_checker
    import zmf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_zmf_out         o_out_data
);

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    // one item in flight: ready drops after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while previous item still in work");

    // idle block stays ready until a beat arrives
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !i_in_valid |=> o_in_ready)
        else $error("ready dropped with no accepted beat");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind zone_temporal_median_filter_unit zmf_checker u_zmf_checker (.*);

// ===== tb/zone_temporal_median_filter_unit_tb.sv =====
`timescale 1ns / 1ps

module zone_temporal_median_filter_unit_tb;
    import zmf_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int POOL_SIZE   = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;

    // expected result beat; the median is only known once every slot of the zone was written
    typedef struct {
        t_zmf_out beat;
        bit       median_known;
    } t_median_expect;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_zmf_in          in_data   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LIM_W-1:0] cfg_wdata = '0;
    logic             in_ready;
    logic             out_valid;
    t_zmf_out         out_data;

    // filter state as seen from outside
    logic [VAL_W-1:0]  hist_val [DEPTH];
    bit                hist_set [DEPTH];
    logic [SLOT_W-1:0] ring_slot   = '0;
    logic [CNT_W-1:0]  frames_done = '0;
    logic [LIM_W-1:0]  clamp_mm    = CLAMP_RESET;

    t_median_expect    expected_medians [$];
    logic [ZONE_W-1:0] zone_pool [POOL_SIZE];
    int                mismatches = 0;
    bit                calm       = 1'b0;
    int                hold_len   = 0;

    zone_temporal_median_filter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // clamp, halve, store, then take the middle of the zone's window
    task automatic predict_median(input t_zmf_in rd);
        t_median_expect    e;
        logic [DIST_W-1:0] d;
        int                vals [WINDOW];
        int                key;
        int                j;
        int                idx;
        e.beat.zone_out     = rd.zone;
        e.beat.median_value = '0;
        e.beat.median_valid = 1'b0;
        e.median_known      = 1'b1;
        if (int'(rd.zone) < ZONES) begin
            d = rd.distance_in;
            if (d > DIST_W'(clamp_mm) || rd.tgt_status == '0) begin
                d = DIST_W'(clamp_mm);
            end
            idx = int'(ring_slot) * ZONES + int'(rd.zone);
            hist_val[idx] = VAL_W'(d >> 1);
            hist_set[idx] = 1'b1;
            for (int i = 0; i < WINDOW; i++) begin
                idx     = i * ZONES + int'(rd.zone);
                vals[i] = int'(hist_val[idx]);
                if (!hist_set[idx]) begin
                    e.median_known = 1'b0;
                end
            end
            // insertion sort of the window
            for (int i = 1; i < WINDOW; i++) begin
                key = vals[i];
                j   = i;
                while (j > 0 && vals[j-1] > key) begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = key;
            end
            e.beat.median_value = VAL_W'(vals[RANK]);
            e.beat.median_valid = (int'(frames_done) + 1 >= WINDOW);
        end
        // frame end moves to the next ring slot
        if (rd.frame_end) begin
            ring_slot = (int'(ring_slot) + 1 >= WINDOW) ? '0 : ring_slot + 1'b1;
            if (int'(frames_done) < WINDOW) begin
                frames_done = frames_done + 1'b1;
            end
        end
        expected_medians.push_back(e);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic t_zmf_in make_reading(input logic [ZONE_W-1:0] z, input int dist_mm,
                                             input int status, input logic fend);
        t_zmf_in r;
        r.zone          = z;
        r.distance_in   = DIST_W'(dist_mm);
        r.tgt_status    = STAT_W'(status);
        r.frame_end     = fend;
        return r;
    endfunction

    // often within range, often near the limit, sometimes anywhere
    function automatic int pick_distance();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return $urandom_range(0, int'(clamp_mm));
        end
        if (r < 7) begin
            v = int'(clamp_mm) + $urandom_range(0, 4) - 2;
            return (v < 0) ? 0 : v;
        end
        return $urandom_range(0, 4095);
    endfunction

    function automatic int pick_status();
        if ($urandom_range(0, 9) < 2) begin
            return 0;
        end
        return $urandom_range(0, 255);
    endfunction

    // one input beat; valid stays up when the next beat follows at once
    task automatic send_reading(input t_zmf_in rd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rd;
        do @(posedge clk); while (in_ready !== 1'b1);
        predict_median(rd);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain_filter();
        in_valid <= 1'b0;
        while (expected_medians.size() != 0) @(posedge clk);
    endtask

    task automatic write_clamp(input logic [LIM_W-1:0] lim);
        drain_filter();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        clamp_mm = lim;
    endtask

    // well-formed frame over the zone pool, frame end on its last beat
    task automatic send_frame(output int count);
        logic [ZONE_W-1:0] zones [$];
        zones = {};
        foreach (zone_pool[i]) begin
            if ($urandom_range(0, 99) < 85) begin
                zones.push_back(zone_pool[i]);
            end
        end
        if (zones.size() == 0) begin
            zones.push_back(zone_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end else if ($urandom_range(0, 7) == 0) begin
            // same zone twice within one frame
            zones.push_back(zones[0]);
        end
        for (int k = 0; k < zones.size(); k++) begin
            send_reading(make_reading(zones[k], pick_distance(), pick_status(),
                                      k == zones.size() - 1));
        end
        count = zones.size();
    endtask

    // fill every slot of the fixed zones; the window fills over these frames
    task automatic test_history_warmup();
        logic [ZONE_W-1:0] fixed_zones [4];
        fixed_zones = '{6'd0, 6'd21, 6'd42, 6'd63};
        for (int f = 0; f < WINDOW; f++) begin
            for (int k = 0; k < 4; k++) begin
                send_reading(make_reading(fixed_zones[k], $urandom_range(0, 600),
                                          $urandom_range(1, 255), k == 3));
            end
        end
    endtask

    // field extremes at the reset limit
    task automatic test_field_extremes();
        send_reading(make_reading(6'd0, 0, 1, 1'b0));
        send_reading(make_reading(6'd63, 4095, 255, 1'b0));
        send_reading(make_reading(6'd21, 510, 128, 1'b0));
        send_reading(make_reading(6'd42, 511, 1, 1'b0));
        send_reading(make_reading(6'd0, 300, 0, 1'b0));
        send_reading(make_reading(6'd21, 4095, 0, 1'b0));
        send_reading(make_reading(6'd42, 1, 255, 1'b0));
        send_reading(make_reading(6'd63, 12'hAAA, 8'h55, 1'b1));
        send_reading(make_reading(6'd0, 12'h555, 8'hAA, 1'b1));
    endtask

    // readings at, just above and far above each limit, plus a missing target
    task automatic test_clamp_limit();
        logic [LIM_W-1:0] limits [4];
        limits = '{9'd511, 9'd0, 9'd1, 9'd255};
        foreach (limits[i]) begin
            write_clamp(limits[i]);
            send_reading(make_reading(6'd0, int'(limits[i]), 7, 1'b0));
            send_reading(make_reading(6'd21, int'(limits[i]) + 1, 200, 1'b0));
            send_reading(make_reading(6'd42, 4095, 255, 1'b0));
            send_reading(make_reading(6'd63, 0, 0, 1'b1));
        end
    endtask

    // random frames under several limits, with stray and broken beats mixed in
    task automatic test_random_frames();
        logic [LIM_W-1:0] limits [5];
        int               sent;
        int               n;
        limits = '{LIM_W'($urandom_range(2, 509)), 9'd511, LIM_W'($urandom_range(2, 509)),
                   9'd0, CLAMP_RESET};
        zone_pool[0] = 6'd0;
        zone_pool[1] = 6'd21;
        zone_pool[2] = 6'd42;
        zone_pool[3] = 6'd63;
        for (int i = 4; i < POOL_SIZE; i++) begin
            zone_pool[i] = ZONE_W'($urandom_range(0, 63));
        end
        foreach (limits[p]) begin
            write_clamp(limits[p]);
            sent = 0;
            while (sent < 150) begin
                calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    send_reading(make_reading(ZONE_W'($urandom_range(0, 63)),
                                              $urandom_range(0, 4095), $urandom_range(0, 255),
                                              1'($urandom_range(0, 1))));
                    sent++;
                end else begin
                    send_frame(n);
                    sent += n;
                end
            end
        end
        calm = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_backpressure();
        int sent;
        int n;
        drain_filter();
        calm     = 1'b1;
        hold_len = HOLD_CYCLES;
        sent     = 0;
        while (sent < 30) begin
            send_frame(n);
            sent += n;
        end
        calm = 1'b0;
    endtask

    // output side ready with random stalls and requested long holds
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                stall_left = hold_len;
                hold_len   = 0;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // compare each result beat with the oldest expectation
    initial begin : median_checker
        t_median_expect e;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready) begin
                if (expected_medians.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: zone %0d median %0d valid %0b",
                                 out_data.zone_out, out_data.median_value,
                                 out_data.median_valid);
                    end
                end else begin
                    e = expected_medians.pop_front();
                    if (out_data.zone_out !== e.beat.zone_out
                        || out_data.median_valid !== e.beat.median_valid
                        || (e.median_known && out_data.median_value !== e.beat.median_value))
                    begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result error: expected zone %0d median %0d valid %0b,",
                                     e.beat.zone_out, e.beat.median_value,
                                     e.beat.median_valid,
                                     " got zone %0d median %0d valid %0b",
                                     out_data.zone_out, out_data.median_value,
                                     out_data.median_valid);
                        end
                    end
                end
            end
        end
    end

    // ends the run when no beat moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("zone_temporal_median_filter_unit: mismatch");
        $finish;
    end

    initial begin : run_tests
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_history_warmup();
        test_field_extremes();
        test_clamp_limit();
        test_random_frames();
        test_output_backpressure();
        drain_filter();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_medians.size() == 0) begin
            $display("zone_temporal_median_filter_unit: match");
        end else begin
            $display("zone_temporal_median_filter_unit: mismatch");
        end
        $finish;
    end

endmodule
